>>> hdl/atke_pkg.sv
// Shared types, action codes and digit helpers for the alarm time keypad editor.
package atke_pkg;

  typedef enum logic [3:0] {
    ACT_TICK       = 4'd0,
    ACT_ENTER      = 4'd1,
    ACT_UP         = 4'd2,
    ACT_DOWN       = 4'd3,
    ACT_LEFT       = 4'd4,
    ACT_RIGHT      = 4'd5,
    ACT_DIGIT      = 4'd6,
    ACT_MODE       = 4'd7,
    ACT_SAVE       = 4'd8,
    ACT_CANCEL     = 4'd9,
    ACT_ENABLE     = 4'd10,
    ACT_DISMISS    = 4'd11,
    ACT_MOVE_LEFT  = 4'd12,
    ACT_MOVE_RIGHT = 4'd13
  } action_t;

  localparam int NUM_DIGITS = 6;
  localparam logic [2:0] LAST_POS = 3'd5;

  localparam logic [3:0] KEY_UP_DIGIT    = 4'd2;
  localparam logic [3:0] KEY_DOWN_DIGIT  = 4'd8;
  localparam logic [3:0] KEY_LEFT_DIGIT  = 4'd4;
  localparam logic [3:0] KEY_RIGHT_DIGIT = 4'd6;

  localparam logic [4:0] MAX_HOUR = 5'd23;
  localparam logic [5:0] MAX_MIN  = 6'd59;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    action_t    action;
    logic [3:0] key_digit;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } atke_item_t;

  typedef struct packed {
    logic        alarm_hit;
    logic        editing;
    logic        direct_mode;
    logic [2:0]  cursor;
    logic        enabled;
    logic [23:0] edit_digits;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [5:0]  alarm_second;
  } atke_result_t;

  // per-position digit limits; hour units limit depends on hour tens
  function automatic digit_t clamp_digit(logic [2:0] pos, digit_t d, digit_t tens_hour);
    digit_t r;
    r = d;
    if (pos == 3'd0 && d > 4'd2) r = 4'd2;
    if (pos == 3'd1 && tens_hour == 4'd2 && d > 4'd3) r = 4'd3;
    if ((pos == 3'd2 || pos == 3'd4) && d > 4'd5) r = 4'd5;
    return r;
  endfunction

  // value below 30 reduced modulo 10
  function automatic digit_t mod10_small(logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd20) r = r - 5'd20;
    else if (r >= 5'd10) r = r - 5'd10;
    return r[3:0];
  endfunction

  function automatic digit_t tens_of(logic [5:0] v);
    digit_t t;
    t = 4'd0;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 6'(k * 10)) t = 4'(k);
    end
    return t;
  endfunction

  function automatic digit_t units_of(logic [5:0] v);
    logic [5:0] u;
    u = v - 6'({2'b00, tens_of(v)} * 6'd10);
    return u[3:0];
  endfunction

  // two BCD digits to binary, up to 165
  function automatic logic [7:0] pair_value(digit_t hi, digit_t lo);
    return ({4'b0000, hi} * 8'd10) + {4'b0000, lo};
  endfunction

endpackage

>>> hdl/atke_core.sv
// Editor state registers and the single-pass per-word update logic.
module atke_core
  import atke_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  atke_item_t   item,
  output atke_result_t res
);

  logic [4:0] stored_hour, stored_hour_next;
  logic [5:0] stored_minute, stored_minute_next;
  logic [5:0] stored_second, stored_second_next;
  logic       armed, armed_next;
  logic       in_edit, in_edit_next;
  logic       direct_entry, direct_entry_next;
  logic [2:0] cursor_pos, cursor_pos_next;
  digit_t     digit_store [NUM_DIGITS];
  digit_t     digit_next [NUM_DIGITS];

  logic       do_direct;
  digit_t     direct_val;
  digit_t     sat_val;
  logic       load_parse;
  logic       do_move;
  logic       move_right;
  logic       do_adjust;
  logic       adjust_up;
  logic [2:0] mv_base;
  digit_t     cur_digit;
  logic [7:0] h_val, m_val, s_val;
  logic       hit;

  always_comb begin
    stored_hour_next   = stored_hour;
    stored_minute_next = stored_minute;
    stored_second_next = stored_second;
    armed_next         = armed;
    in_edit_next       = in_edit;
    direct_entry_next  = direct_entry;
    cursor_pos_next    = cursor_pos;
    digit_next         = digit_store;
    do_direct          = 1'b0;
    direct_val         = item.key_digit;
    load_parse         = 1'b0;
    do_move            = 1'b0;
    move_right         = 1'b0;
    do_adjust          = 1'b0;
    adjust_up          = 1'b0;
    hit                = 1'b0;
    sat_val            = 4'd0;
    mv_base            = 3'd0;
    cur_digit          = 4'd0;
    h_val              = 8'd0;
    m_val              = 8'd0;
    s_val              = 8'd0;

    if (item.action == ACT_TICK) begin
      hit = armed && item.now_hour == stored_hour && item.now_minute == stored_minute
            && item.now_second == stored_second;
    end else if (item.action == ACT_DISMISS) begin
      armed_next = 1'b0;
    end else if (!in_edit) begin
      if (item.action == ACT_ENTER) begin
        in_edit_next      = 1'b1;
        direct_entry_next = 1'b0;
        digit_next[0] = tens_of({1'b0, stored_hour});
        digit_next[1] = units_of({1'b0, stored_hour});
        digit_next[2] = tens_of(stored_minute);
        digit_next[3] = units_of(stored_minute);
        digit_next[4] = tens_of(stored_second);
        digit_next[5] = units_of(stored_second);
      end else if (item.action == ACT_ENABLE) begin
        armed_next = !armed;
      end
    end else begin
      unique case (item.action)
        ACT_UP: begin
          do_direct = direct_entry;
          direct_val = KEY_UP_DIGIT;
          do_adjust = !direct_entry;
          adjust_up = 1'b1;
        end
        ACT_DOWN: begin
          do_direct = direct_entry;
          direct_val = KEY_DOWN_DIGIT;
          do_adjust = !direct_entry;
        end
        ACT_LEFT: begin
          do_direct = direct_entry;
          direct_val = KEY_LEFT_DIGIT;
          do_move = !direct_entry;
        end
        ACT_RIGHT: begin
          do_direct = direct_entry;
          direct_val = KEY_RIGHT_DIGIT;
          do_move = !direct_entry;
          move_right = 1'b1;
        end
        ACT_DIGIT:  do_direct = direct_entry;
        ACT_MODE:   direct_entry_next = !direct_entry;
        ACT_SAVE: begin
          load_parse   = 1'b1;
          armed_next   = 1'b1;
          in_edit_next = 1'b0;
        end
        ACT_CANCEL: begin
          in_edit_next      = 1'b0;
          direct_entry_next = 1'b0;
        end
        ACT_MOVE_LEFT:  do_move = direct_entry;
        ACT_MOVE_RIGHT: begin
          do_move = direct_entry;
          move_right = 1'b1;
        end
        default: ;
      endcase
    end

    if (do_adjust && cursor_pos <= LAST_POS) begin
      cur_digit = digit_store[cursor_pos];
      cur_digit = adjust_up ? mod10_small({1'b0, cur_digit} + 5'd11)
                            : mod10_small({1'b0, cur_digit} + 5'd9);
      digit_next[cursor_pos] = clamp_digit(cursor_pos, cur_digit, digit_store[0]);
    end

    if (do_move) begin
      mv_base = (cursor_pos > LAST_POS) ? 3'd0 : cursor_pos;
      if (move_right) cursor_pos_next = (mv_base == LAST_POS) ? 3'd0 : mv_base + 3'd1;
      else            cursor_pos_next = (mv_base == 3'd0) ? LAST_POS : mv_base - 3'd1;
    end

    if (do_direct && cursor_pos <= LAST_POS) begin
      sat_val = (direct_val > 4'd9) ? 4'd9 : direct_val;
      digit_next[cursor_pos] = clamp_digit(cursor_pos, sat_val, digit_store[0]);
      cursor_pos_next = (cursor_pos == LAST_POS) ? 3'd0 : cursor_pos + 3'd1;
      load_parse = 1'b1;
    end

    if (load_parse) begin
      h_val = pair_value(digit_next[0], digit_next[1]);
      m_val = pair_value(digit_next[2], digit_next[3]);
      s_val = pair_value(digit_next[4], digit_next[5]);
      stored_hour_next   = (h_val > {3'b000, MAX_HOUR}) ? MAX_HOUR : h_val[4:0];
      stored_minute_next = (m_val > {2'b00, MAX_MIN}) ? MAX_MIN : m_val[5:0];
      stored_second_next = (s_val > {2'b00, MAX_MIN}) ? MAX_MIN : s_val[5:0];
    end
  end

  always_comb begin
    res.alarm_hit    = hit;
    res.editing      = in_edit_next;
    res.direct_mode  = direct_entry_next;
    res.cursor       = cursor_pos_next;
    res.enabled      = armed_next;
    res.edit_digits  = {digit_next[0], digit_next[1], digit_next[2],
                        digit_next[3], digit_next[4], digit_next[5]};
    res.alarm_hour   = stored_hour_next;
    res.alarm_minute = stored_minute_next;
    res.alarm_second = stored_second_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_hour   <= '0;
      stored_minute <= '0;
      stored_second <= '0;
      armed         <= 1'b0;
      in_edit       <= 1'b0;
      direct_entry  <= 1'b0;
      cursor_pos    <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) digit_store[i] <= '0;
    end else if (step) begin
      stored_hour   <= stored_hour_next;
      stored_minute <= stored_minute_next;
      stored_second <= stored_second_next;
      armed         <= armed_next;
      in_edit       <= in_edit_next;
      direct_entry  <= direct_entry_next;
      cursor_pos    <= cursor_pos_next;
      digit_store   <= digit_next;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor_pos <= LAST_POS) else $error("cursor out of range");

  a_stored_range: assert property (@(posedge clk) disable iff (rst)
    stored_hour <= MAX_HOUR && stored_minute <= MAX_MIN && stored_second <= MAX_MIN)
    else $error("stored alarm time out of range");

  a_hit_armed: assert property (@(posedge clk) disable iff (rst)
    step && res.alarm_hit |-> armed && item.action == ACT_TICK)
    else $error("alarm hit while disarmed");

  a_save_exit: assert property (@(posedge clk) disable iff (rst)
    step && in_edit && item.action == ACT_SAVE |=> !in_edit && armed)
    else $error("save did not arm and leave edit");

endmodule

>>> hdl/alarm_time_keypad_editor_top.sv
// Top level: stream ports, input word register and result word register.
//
// Alarm time keypad editor. Each input word is one key event or clock tick;
// each produces exactly one result word carrying the full editor status.
// Input channel s_*: s_tuser holds the action code, s_tdata the typed digit
// and the current clock time. Output channel m_*: m_tdata holds the hit flag,
// mode flags, cursor, enable flag, six BCD edit digits and stored alarm time.
// A word accepted into the input register is processed once the result register
// is free (empty, or its word being taken); that step loads the result register,
// where the result is held on m_* until taken.
// Throughput: one word per cycle unless m_tready stalls; the update is a single
// combinational pass from the input register and editor state into the result register.
// Reset (rst, synchronous) clears the alarm time, enable, edit state, cursor
// and edit digits, and empties both registers.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; s_tready drops only when both are full.
module alarm_time_keypad_editor_top
  import atke_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // key_digit[3:0], now_hour[8:4], now_minute[14:9],
                                // now_second[20:15], zero pad[23:21]
  input  logic [3:0]  s_tuser,  // action[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // alarm_hit[0], editing[1], direct_mode[2], cursor[5:3],
                                // enabled[6], edit_digits[30:7], alarm_hour[35:31],
                                // alarm_minute[41:36], alarm_second[47:42]
);

  logic         in_valid;
  atke_item_t   in_item;
  logic         out_valid;
  atke_result_t out_res;
  atke_result_t res;
  logic         step;

  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  atke_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action     <= action_t'(s_tuser);
      in_item.key_digit  <= s_tdata[3:0];
      in_item.now_hour   <= s_tdata[8:4];
      in_item.now_minute <= s_tdata[14:9];
      in_item.now_second <= s_tdata[20:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.alarm_second, out_res.alarm_minute, out_res.alarm_hour,
                     out_res.edit_digits, out_res.enabled, out_res.cursor,
                     out_res.direct_mode, out_res.editing, out_res.alarm_hit};

endmodule

>>> bench/alarm_time_keypad_editor_top_test.sv
// Self-checking testbench for the alarm time keypad editor: key words in, status words out.
`timescale 1ns / 100ps

module alarm_time_keypad_editor_top_test;
  import atke_pkg::*;

  localparam logic [3:0] ACT_SPARE_A = 4'd14;
  localparam logic [3:0] ACT_SPARE_B = 4'd15;
  localparam int CYCLE_LIMIT = 200000;
  localparam int KEY_TARGET  = 1700;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [3:0] action;
    logic [3:0] key_digit;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } key_word_t;

  typedef struct {
    logic        hit;
    logic        editing;
    logic        direct;
    logic [2:0]  cursor;
    logic        armed;
    logic [23:0] digits;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  alarm_time_keypad_editor_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_word_t key_queue[$];
  status_t   status_queue[$];
  int        error_count = 0;
  int        cycles = 0;
  int        keys_sent = 0;
  int        words_seen = 0;
  int        hold_left = 0;
  bit        hold_done = 0;

  // editor shadow state
  logic [4:0] sh_hour;
  logic [5:0] sh_minute, sh_second;
  logic       sh_armed, sh_editing, sh_direct;
  logic [2:0] sh_cursor;
  logic [3:0] sh_dig[6];

  function automatic logic [3:0] limit_digit(logic [2:0] pos, logic [3:0] d);
    logic [3:0] r;
    r = d;
    if (pos == 3'd0 && r > 4'd2) r = 4'd2;
    if (pos == 3'd1 && sh_dig[0] == 4'd2 && r > 4'd3) r = 4'd3;
    if ((pos == 3'd2 || pos == 3'd4) && r > 4'd5) r = 4'd5;
    return r;
  endfunction

  function automatic void digits_to_time();
    int h, m, s;
    h = sh_dig[0] * 10 + sh_dig[1];
    m = sh_dig[2] * 10 + sh_dig[3];
    s = sh_dig[4] * 10 + sh_dig[5];
    sh_hour   = (h > 23) ? 5'd23 : 5'(h);
    sh_minute = (m > 59) ? 6'd59 : 6'(m);
    sh_second = (s > 59) ? 6'd59 : 6'(s);
  endfunction

  function automatic void roll_digit(bit up);
    int d;
    d = int'(sh_dig[sh_cursor]);
    d = up ? (d + 1) % 10 : (d + 9) % 10;
    sh_dig[sh_cursor] = limit_digit(sh_cursor, 4'(d));
  endfunction

  function automatic void step_cursor(bit right);
    if (right) sh_cursor = (sh_cursor == LAST_POS) ? 3'd0 : sh_cursor + 3'd1;
    else       sh_cursor = (sh_cursor == 3'd0) ? LAST_POS : sh_cursor - 3'd1;
  endfunction

  function automatic void type_digit(logic [3:0] num);
    logic [3:0] n;
    n = (num > 4'd9) ? 4'd9 : num;
    sh_dig[sh_cursor] = limit_digit(sh_cursor, n);
    step_cursor(1'b1);
    digits_to_time();
  endfunction

  function automatic status_t apply_key(key_word_t w);
    status_t st;
    st.hit = 1'b0;
    if (w.action == ACT_TICK) begin
      st.hit = sh_armed && w.hour == sh_hour && w.minute == sh_minute && w.second == sh_second;
    end else if (w.action == ACT_DISMISS) begin
      sh_armed = 1'b0;
    end else if (!sh_editing) begin
      if (w.action == ACT_ENTER) begin
        sh_editing = 1'b1;
        sh_direct  = 1'b0;
        sh_dig[0] = 4'(sh_hour / 10);
        sh_dig[1] = 4'(sh_hour % 10);
        sh_dig[2] = 4'(sh_minute / 10);
        sh_dig[3] = 4'(sh_minute % 10);
        sh_dig[4] = 4'(sh_second / 10);
        sh_dig[5] = 4'(sh_second % 10);
      end else if (w.action == ACT_ENABLE) begin
        sh_armed = !sh_armed;
      end
    end else begin
      case (w.action)
        ACT_UP:         if (sh_direct) type_digit(KEY_UP_DIGIT); else roll_digit(1'b1);
        ACT_DOWN:       if (sh_direct) type_digit(KEY_DOWN_DIGIT); else roll_digit(1'b0);
        ACT_LEFT:       if (sh_direct) type_digit(KEY_LEFT_DIGIT); else step_cursor(1'b0);
        ACT_RIGHT:      if (sh_direct) type_digit(KEY_RIGHT_DIGIT); else step_cursor(1'b1);
        ACT_DIGIT:      if (sh_direct) type_digit(w.key_digit);
        ACT_MODE:       sh_direct = !sh_direct;
        ACT_SAVE: begin
          digits_to_time();
          sh_armed   = 1'b1;
          sh_editing = 1'b0;
        end
        ACT_CANCEL: begin
          sh_editing = 1'b0;
          sh_direct  = 1'b0;
        end
        ACT_MOVE_LEFT:  if (sh_direct) step_cursor(1'b0);
        ACT_MOVE_RIGHT: if (sh_direct) step_cursor(1'b1);
        default: ;
      endcase
    end
    st.editing = sh_editing;
    st.direct  = sh_direct;
    st.cursor  = sh_cursor;
    st.armed   = sh_armed;
    st.digits  = {sh_dig[0], sh_dig[1], sh_dig[2], sh_dig[3], sh_dig[4], sh_dig[5]};
    st.hour    = sh_hour;
    st.minute  = sh_minute;
    st.second  = sh_second;
    return st;
  endfunction

  function automatic void push_word(logic [3:0] act, logic [3:0] kd,
                                    logic [4:0] h, logic [5:0] m, logic [5:0] s);
    key_word_t w;
    w.action = act;
    w.key_digit = kd;
    w.hour = h;
    w.minute = m;
    w.second = s;
    key_queue.push_back(w);
    status_queue.push_back(apply_key(w));
  endfunction

  function automatic void push_key(logic [3:0] act, logic [3:0] kd);
    push_word(act, kd, 5'($urandom), 6'($urandom), 6'($urandom));
  endfunction

  // tick at the alarm time, sometimes with one field or all three knocked off
  function automatic void push_tick();
    logic [4:0] h;
    logic [5:0] m, s;
    h = sh_hour;
    m = sh_minute;
    s = sh_second;
    case ($urandom_range(5))
      0: h = 5'($urandom);
      1: m = 6'($urandom);
      2: s = 6'($urandom);
      3: begin
        h = 5'($urandom);
        m = 6'($urandom);
        s = 6'($urandom);
      end
      default: ;
    endcase
    push_word(ACT_TICK, 4'($urandom), h, m, s);
  endfunction

  // returns 1 when the word is shaped to do something
  function automatic bit push_random();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      push_word(4'($urandom), 4'($urandom), 5'($urandom), 6'($urandom), 6'($urandom));
      return 1'b0;
    end
    if (!sh_editing) begin
      if (r < 45) push_tick();
      else if (r < 58) push_key(ACT_ENABLE, 4'($urandom));
      else if (r < 63) push_key(ACT_DISMISS, 4'($urandom));
      else push_key(ACT_ENTER, 4'($urandom));
    end else begin
      if (r < 22) push_key($urandom_range(1) ? ACT_UP : ACT_DOWN, 4'($urandom));
      else if (r < 36) push_key($urandom_range(1) ? ACT_LEFT : ACT_RIGHT, 4'($urandom));
      else if (r < 58) push_key(ACT_DIGIT, ($urandom_range(9) == 0) ?
                                4'($urandom_range(15, 10)) : 4'($urandom_range(9)));
      else if (r < 70) push_key($urandom_range(1) ? ACT_MOVE_LEFT : ACT_MOVE_RIGHT,
                                4'($urandom));
      else if (r < 78) push_key(ACT_MODE, 4'($urandom));
      else if (r < 85) push_key(ACT_SAVE, 4'($urandom));
      else if (r < 88) push_key(ACT_CANCEL, 4'($urandom));
      else if (r < 96) push_tick();
      else if (r < 98) push_key(ACT_DISMISS, 4'($urandom));
      else push_key($urandom_range(1) ? ACT_ENTER : ACT_ENABLE, 4'($urandom));
    end
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      error_count++;
    end
  endtask

  initial begin
    sh_hour = '0;
    sh_minute = '0;
    sh_second = '0;
    sh_armed = 1'b0;
    sh_editing = 1'b0;
    sh_direct = 1'b0;
    sh_cursor = '0;
    for (int i = 0; i < NUM_DIGITS; i++) sh_dig[i] = '0;

    // directed opening
    push_word(ACT_TICK, 4'd0, 5'd0, 6'd0, 6'd0);
    push_key(ACT_ENABLE, 4'd0);
    push_word(ACT_TICK, 4'd0, 5'd0, 6'd0, 6'd0);
    push_word(ACT_TICK, 4'd15, 5'd31, 6'd63, 6'd63);
    push_key(ACT_DIGIT, 4'd5);
    push_key(ACT_ENTER, 4'd0);
    push_key(ACT_DOWN, 4'd0);        // wraps to 9, held at 2
    push_key(ACT_RIGHT, 4'd0);
    push_key(ACT_DOWN, 4'd0);        // hour units held at 3
    push_key(ACT_LEFT, 4'd0);
    push_key(ACT_LEFT, 4'd0);        // cursor wraps to the last digit
    push_key(ACT_RIGHT, 4'd0);
    push_key(ACT_DIGIT, 4'd7);       // ignored in arrow mode
    push_key(ACT_MOVE_RIGHT, 4'd0);
    push_key(ACT_ENABLE, 4'd0);
    push_key(ACT_MODE, 4'd0);
    push_key(ACT_DIGIT, 4'd15);      // saturates, then clamped
    push_key(ACT_UP, 4'd0);
    push_key(ACT_DOWN, 4'd0);
    push_key(ACT_LEFT, 4'd0);
    push_key(ACT_RIGHT, 4'd0);
    push_key(ACT_DIGIT, 4'd9);
    push_key(ACT_MOVE_LEFT, 4'd0);
    push_key(ACT_MOVE_RIGHT, 4'd0);
    push_key(ACT_SAVE, 4'd0);
    push_tick();
    push_key(ACT_DISMISS, 4'd0);
    push_key(ACT_ENTER, 4'd0);
    push_key(ACT_CANCEL, 4'd0);
    push_key(ACT_SPARE_A, 4'd0);
    push_key(ACT_SPARE_B, 4'd0);

    while (key_queue.size() < KEY_TARGET) void'(push_random());

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (key_queue.size() != 0 || status_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && status_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    key_word_t w;
    int idle_pct;
    if (!rst) begin
      if (s_tvalid && s_tready) keys_sent++;
      idle_pct = (keys_sent < 600) ? 24 : (keys_sent < 1200) ? 45 : 0;
      if (!s_tvalid || s_tready) begin
        if (key_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          w = key_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= w.action;
          s_tdata  <= {3'b000, w.second, w.minute, w.hour, w.key_digit};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so both stages fill and s_tready drops
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && words_seen >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 60;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    status_t want;
    int idle_pct;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (status_queue.size() == 0) begin
          $error("status word with nothing expected: 'h%0h", m_tdata);
          error_count++;
        end else begin
          want = status_queue.pop_front();
          check_field("alarm_hit", 32'(want.hit), 32'(m_tdata[0]));
          check_field("editing", 32'(want.editing), 32'(m_tdata[1]));
          check_field("direct_mode", 32'(want.direct), 32'(m_tdata[2]));
          check_field("cursor", 32'(want.cursor), 32'(m_tdata[5:3]));
          check_field("enabled", 32'(want.armed), 32'(m_tdata[6]));
          check_field("edit_digits", 32'(want.digits), 32'(m_tdata[30:7]));
          check_field("alarm_hour", 32'(want.hour), 32'(m_tdata[35:31]));
          check_field("alarm_minute", 32'(want.minute), 32'(m_tdata[41:36]));
          check_field("alarm_second", 32'(want.second), 32'(m_tdata[47:42]));
        end
      end
      idle_pct = (words_seen < 600) ? 45 : (words_seen < 1200) ? 24 : 0;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

>>> filelist.f
hdl/atke_pkg.sv
hdl/atke_core.sv
hdl/alarm_time_keypad_editor_top.sv
bench/alarm_time_keypad_editor_top_test.sv
